// File: rtl/core/assert_macros.svh
// assertion macros shared by the rtl files of the mean squared residue block
// no dependencies; synthesis builds get empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MSR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define MSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MSR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define MSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: rtl/core/msr_pkg.sv
// shared types and fixed constants of the mean squared residue block
// no dependencies
`default_nettype none
package msr_pkg;
  localparam int ELEM_W = 24;
  localparam int OUT_W = 52;
  localparam int CFG_W = 7;
  localparam int REG_IDX_W = 1;
  localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;
  localparam logic [REG_IDX_W-1:0] REG_ROWS = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_COLS = 1'd1;
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  // request to the shared divider
  typedef struct packed {
    logic start;
    logic long_op;
  } div_req_t;
endpackage
`default_nettype wire

// File: rtl/core/mean_squared_residue_top.sv
// mean squared residue of a loaded bicluster submatrix
// depends on msr_pkg, msr_div and assert_macros.svh
//
//  channel   ports                                   handshake
//  input     start_i, elem_value_i, first_flag_i     start_i & !busy_o
//  result    done_o, msr_value_o                     one-cycle strobe done_o
//  config    cfg_we_i, cfg_idx_i, cfg_data_i         cfg_we_i
//
// an element is handled as store write and column sum read, then sum update
// after the last element the row, column and grand means are divided on the
// shared divider, then the residue pass reads each element store entry once,
// and the final divide by the element count precedes the result strobe
// reset clears control only; stores are read only where the current load wrote
// busy_o holds off start_i; the result cannot be stalled
`default_nettype none
`include "assert_macros.svh"
module mean_squared_residue_top #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  output logic                                      busy_o,
  input  wire logic signed [msr_pkg::ELEM_W-1:0]    elem_value_i,
  input  wire logic                                 first_flag_i,
  output logic                                      done_o,
  output logic [msr_pkg::OUT_W-1:0]                 msr_value_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [msr_pkg::REG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [msr_pkg::CFG_W-1:0]            cfg_data_i
);
  localparam int EW = msr_pkg::ELEM_W;
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int RI = $clog2(MAX_ROWS);
  localparam int CI = $clog2(MAX_COLS);
  localparam int IX = (RI > CI) ? RI : CI;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);
  localparam int RS_W = EW + CI;
  localparam int CS_W = EW + RI;
  localparam int GS_W = EW + RI + CI;
  localparam int D_W = EW + 2;
  localparam int SQ_W = 2 * D_W - 1;
  localparam int ACC_W = SQ_W + AW;
  localparam int CMP_W = (RW > CW ? RW : CW) > msr_pkg::CFG_W ?
                         (RW > CW ? RW : CW) : msr_pkg::CFG_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_COLW   = 7'b0000010,
    S_MRD    = 7'b0000100,
    S_MSTART = 7'b0001000,
    S_MWAIT  = 7'b0010000,
    S_PASS   = 7'b0100000,
    S_FWAIT  = 7'b1000000
  } state_e;

  typedef enum logic [2:0] {
    SEL_ROW   = 3'b001,
    SEL_COL   = 3'b010,
    SEL_GRAND = 3'b100
  } sel_e;

  // memories
  logic signed [EW-1:0]   el_mem [DEPTH];
  logic signed [RS_W-1:0] rs_mem [MAX_ROWS];
  logic signed [CS_W-1:0] cs_mem [MAX_COLS];
  logic signed [EW-1:0]   rm_mem [MAX_ROWS];
  logic signed [EW-1:0]   cm_mem [MAX_COLS];

  state_e state_q;
  sel_e   sel_q;
  logic [msr_pkg::CFG_W-1:0] rows_cfg_q, cols_cfg_q;
  logic                loading_q;
  logic [RW-1:0]       lat_r_q, r_eff;
  logic [CW-1:0]       lat_c_q, c_eff;
  logic [NW-1:0]       lat_n_q;
  logic [AW-1:0]       cnt_q;
  logic [RI-1:0]       row_q;
  logic [CI-1:0]       col_q;
  logic signed [RS_W-1:0] row_acc_q;
  logic signed [GS_W-1:0] grand_q;
  logic signed [EW-1:0] pv_q;
  logic [RI-1:0]       prow_q;
  logic [CI-1:0]       pcol_q;
  logic [AW-1:0]       pcnt_q;
  logic [IX-1:0]       idx_q;
  logic                mean_neg_q;
  logic signed [EW-1:0] gm_q;
  logic [AW-1:0]       paddr_q;
  logic [RI-1:0]       pi_q;
  logic [CI-1:0]       pj_q;
  logic                issuing_q, p1_q, p2_q, p3_q;
  logic signed [D_W-1:0] d_q;
  logic [SQ_W-1:0]     sq_q;
  logic [ACC_W-1:0]    acc_q;
  logic                done_q;
  logic [msr_pkg::OUT_W-1:0] msr_q;

  logic signed [RS_W-1:0] rs_rd_q;
  logic signed [CS_W-1:0] cs_rd_q;
  logic signed [EW-1:0]   el_rd_q, rm_rd_q, cm_rd_q;

  logic                take;
  logic [AW-1:0]       e_cnt;
  logic [RI-1:0]       e_row;
  logic [CI-1:0]       e_col;
  logic [CI-1:0]       cs_raddr;
  logic [CMP_W-1:0]    rcmp, ccmp;
  logic signed [CS_W-1:0] cs_new;
  logic signed [RS_W-1:0] racc_new;
  logic                last_col, last_row;
  logic [RI-1:0]       r_last;
  logic [CI-1:0]       c_last;
  logic signed [GS_W-1:0] mean_src;
  logic [GS_W-1:0]     mean_mag;
  logic [NW-1:0]       divisor;
  logic [ACC_W-1:0]    dividend;
  msr_pkg::div_req_t   div_req;
  logic                div_done;
  logic [ACC_W-1:0]    quotient;
  logic [EW-1:0]       mean_q_bits;
  logic signed [EW-1:0] mean_val;
  logic                drained;
  logic signed [2*D_W-1:0] prod;

  // dimension clamp: zero counts as one, above maximum counts as maximum
  always_comb begin
    rcmp = CMP_W'(rows_cfg_q);
    ccmp = CMP_W'(cols_cfg_q);
    if (rcmp == '0) r_eff = RW'(1);
    else if (rcmp > CMP_W'(MAX_ROWS)) r_eff = RW'(MAX_ROWS);
    else r_eff = rcmp[RW-1:0];
    if (ccmp == '0) c_eff = CW'(1);
    else if (ccmp > CMP_W'(MAX_COLS)) c_eff = CW'(MAX_COLS);
    else c_eff = ccmp[CW-1:0];
  end

  // load position of an accepted element
  assign take = start_i && (state_q == S_IDLE) && (first_flag_i || loading_q);
  assign e_cnt = first_flag_i ? '0 : cnt_q;
  assign e_row = first_flag_i ? '0 : row_q;
  assign e_col = first_flag_i ? '0 : col_q;
  assign cs_raddr = (state_q == S_IDLE) ? e_col : idx_q[CI-1:0];

  // sum update of the pending element
  assign r_last = RI'(lat_r_q - RW'(1));
  assign c_last = CI'(lat_c_q - CW'(1));
  assign last_col = pcol_q == c_last;
  assign last_row = prow_q == r_last;
  assign cs_new = ((prow_q == '0) ? CS_W'(0) : cs_rd_q) + CS_W'(pv_q);
  assign racc_new = ((pcol_q == '0) ? RS_W'(0) : row_acc_q) + RS_W'(pv_q);

  // mean operand selection
  always_comb begin
    case (sel_q)
      SEL_ROW: begin
        mean_src = GS_W'(rs_rd_q);
        divisor = NW'(lat_c_q);
      end
      SEL_COL: begin
        mean_src = GS_W'(cs_rd_q);
        divisor = NW'(lat_r_q);
      end
      default: begin
        mean_src = grand_q;
        divisor = lat_n_q;
      end
    endcase
    mean_mag = mean_src[GS_W-1] ? GS_W'(-mean_src) : GS_W'(mean_src);
  end

  assign mean_q_bits = quotient[EW-1:0];
  assign mean_val = mean_neg_q ? -$signed(mean_q_bits) : $signed(mean_q_bits);
  assign drained = !issuing_q && !p1_q && !p2_q && !p3_q;

  // divider requests
  always_comb begin
    div_req.start = 1'b0;
    div_req.long_op = 1'b0;
    dividend = ACC_W'(mean_mag);
    if (state_q == S_MSTART) begin
      div_req.start = 1'b1;
    end else if (state_q == S_PASS && drained) begin
      div_req.start = 1'b1;
      div_req.long_op = 1'b1;
      dividend = acc_q;
    end
  end

  msr_div #(
    .DW(ACC_W),
    .NW(NW),
    .SHORT_STEPS(GS_W)
  ) u_div (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .req_i(div_req),
    .dividend_i(dividend),
    .divisor_i(divisor),
    .done_o(div_done),
    .quotient_o(quotient)
  );

  // memory ports
  always_ff @(posedge clk_i) begin
    if (take) el_mem[e_cnt] <= elem_value_i;
    el_rd_q <= el_mem[paddr_q];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_COLW) cs_mem[pcol_q] <= cs_new;
    cs_rd_q <= cs_mem[cs_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_COLW && last_col) rs_mem[prow_q] <= racc_new;
    rs_rd_q <= rs_mem[idx_q[RI-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_MWAIT && div_done && sel_q == SEL_ROW) rm_mem[idx_q[RI-1:0]] <= mean_val;
    rm_rd_q <= rm_mem[pi_q];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_MWAIT && div_done && sel_q == SEL_COL) cm_mem[idx_q[CI-1:0]] <= mean_val;
    cm_rd_q <= cm_mem[pj_q];
  end

  // residue pipeline datapath
  assign prod = d_q * d_q;
  always_ff @(posedge clk_i) begin
    d_q <= D_W'(el_rd_q) - D_W'(rm_rd_q) - D_W'(cm_rd_q) + D_W'(gm_q);
    sq_q <= prod[SQ_W-1:0];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= msr_pkg::DIM_RESET;
      cols_cfg_q <= msr_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        msr_pkg::REG_ROWS: rows_cfg_q <= cfg_data_i;
        msr_pkg::REG_COLS: cols_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q <= SEL_ROW;
      loading_q <= 1'b0;
      lat_r_q <= RW'(MAX_ROWS);
      lat_c_q <= CW'(MAX_COLS);
      lat_n_q <= NW'(DEPTH);
      cnt_q <= '0;
      row_q <= '0;
      col_q <= '0;
      idx_q <= '0;
      issuing_q <= 1'b0;
      p1_q <= 1'b0;
      p2_q <= 1'b0;
      p3_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      p2_q <= p1_q;
      p3_q <= p2_q;
      case (state_q)
        S_IDLE: begin
          if (take) begin
            if (first_flag_i) begin
              lat_r_q <= r_eff;
              lat_c_q <= c_eff;
              lat_n_q <= NW'(r_eff) * NW'(c_eff);
            end
            loading_q <= 1'b1;
            state_q <= S_COLW;
          end
        end
        S_COLW: begin
          if (last_col && last_row) begin
            loading_q <= 1'b0;
            cnt_q <= '0;
            row_q <= '0;
            col_q <= '0;
            idx_q <= '0;
            sel_q <= SEL_ROW;
            state_q <= S_MRD;
          end else begin
            cnt_q <= pcnt_q + AW'(1);
            col_q <= last_col ? '0 : pcol_q + CI'(1);
            row_q <= last_col ? prow_q + RI'(1) : prow_q;
            state_q <= S_IDLE;
          end
        end
        S_MRD: state_q <= S_MSTART;
        S_MSTART: state_q <= S_MWAIT;
        S_MWAIT: begin
          if (div_done) begin
            case (sel_q)
              SEL_ROW: begin
                idx_q <= (idx_q == IX'(r_last)) ? '0 : idx_q + IX'(1);
                if (idx_q == IX'(r_last)) sel_q <= SEL_COL;
                state_q <= S_MRD;
              end
              SEL_COL: begin
                idx_q <= (idx_q == IX'(c_last)) ? '0 : idx_q + IX'(1);
                if (idx_q == IX'(c_last)) sel_q <= SEL_GRAND;
                state_q <= S_MRD;
              end
              default: begin
                issuing_q <= 1'b1;
                state_q <= S_PASS;
              end
            endcase
          end
        end
        S_PASS: begin
          p1_q <= issuing_q;
          if (issuing_q && pi_q == r_last && pj_q == c_last) issuing_q <= 1'b0;
          if (drained) state_q <= S_FWAIT;
        end
        S_FWAIT: begin
          if (div_done) begin
            done_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      pv_q <= elem_value_i;
      prow_q <= e_row;
      pcol_q <= e_col;
      pcnt_q <= e_cnt;
      if (first_flag_i) grand_q <= '0;
    end
    if (state_q == S_COLW) begin
      row_acc_q <= racc_new;
      grand_q <= grand_q + GS_W'(pv_q);
    end
    if (state_q == S_MSTART) mean_neg_q <= mean_src[GS_W-1];
    if (state_q == S_MWAIT && div_done && sel_q == SEL_GRAND) gm_q <= mean_val;
    // residue pass addressing and accumulation
    if (state_q == S_MWAIT && div_done && sel_q == SEL_GRAND) begin
      paddr_q <= '0;
      pi_q <= '0;
      pj_q <= '0;
      acc_q <= '0;
    end else if (state_q == S_PASS) begin
      if (issuing_q) begin
        paddr_q <= paddr_q + AW'(1);
        pj_q <= (pj_q == c_last) ? '0 : pj_q + CI'(1);
        if (pj_q == c_last) pi_q <= pi_q + RI'(1);
      end
      if (p3_q) acc_q <= acc_q + ACC_W'(sq_q);
    end
    // saturated result
    if (state_q == S_FWAIT && div_done) begin
      msr_q <= (quotient > ACC_W'(msr_pkg::OUT_MAX)) ? msr_pkg::OUT_MAX
                                                     : quotient[msr_pkg::OUT_W-1:0];
    end
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = done_q;
  assign msr_value_o = msr_q;

  `MSR_ASSERT_NEXT(a_take_to_colw, clk_i, rst_ni, take, state_q == S_COLW, "accepted word not processed")
  `MSR_ASSERT_NEXT(a_colw_exit, clk_i, rst_ni, state_q == S_COLW, state_q == S_IDLE || state_q == S_MRD, "bad exit from sum update")
  `MSR_ASSERT_NOW(a_done_from_div, clk_i, rst_ni, done_o, $past(state_q == S_FWAIT) && state_q == S_IDLE, "result without final divide")
endmodule
`default_nettype wire

// File: rtl/core/msr_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on msr_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module msr_div #(
  parameter int DW = 64,
  parameter int NW = 13,
  parameter int SHORT_STEPS = 37
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire msr_pkg::div_req_t req_i,
  input  wire logic [DW-1:0]     dividend_i,
  input  wire logic [NW-1:0]     divisor_i,
  output logic                   done_o,
  output logic [DW-1:0]          quotient_o
);
  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    quo_q, quo_d;
  logic [NW-1:0]    rem_q, rem_d;
  logic [NW-1:0]    dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [NW:0]      trial;
  logic             ge;
  logic [NW:0]      diff;

  // one trial subtraction per cycle
  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    ge = trial >= {1'b0, dvs_q};
    diff = trial - {1'b0, dvs_q};
    rem_d = ge ? diff[NW-1:0] : trial[NW-1:0];
    quo_d = {quo_q[DW-2:0], ge};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q <= req_i.long_op ? CNT_W'(DW) : CNT_W'(SHORT_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath, short operands start left aligned
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.long_op ? dividend_i : (dividend_i << (DW - SHORT_STEPS));
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quotient_o = quo_q;

  `MSR_ASSERT_NOW(a_no_start_busy, clk_i, rst_ni, req_i.start, !busy_q, "divider restarted while busy")
  `MSR_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_q, !done_q, "divider done longer than one cycle")
endmodule
`default_nettype wire
